// ===== src/stoq_pkg.sv =====
// Shared types, codes and defaults for the start-time ordered ready queue.
package stoq_pkg;

  // Default sizes
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_KEY_BITS    = 16;
  localparam int DEF_ID_BITS     = 8;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FLAGS,
    S_SPREAD,
    S_APPLY,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the input transfer
    logic flags;   // compute per-slot compare flags, clear spread step
    logic spread;  // one prefix-OR doubling step over the slot row
    logic apply;   // update slots and occupancy, latch status
    logic emit;    // load the output register
  } stoq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic do_spread;    // captured op is an insert into a non-full queue
    logic spread_last;  // current doubling step is the final one
    logic out_free;     // output register can take a new result
  } stoq_sts_t;

endpackage

// ===== src/stoq_ctrl.sv =====
// Controller state machine sequencing one queue operation at a time.
module stoq_ctrl
  import stoq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  stoq_sts_t sts,
  output stoq_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_FLAGS;
        end
      end
      S_FLAGS: begin
        cmd.flags = 1'b1;
        if (sts.do_spread) begin
          state_next = S_SPREAD;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_SPREAD: begin
        cmd.spread = 1'b1;
        if (sts.spread_last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/stoq_dpath.sv =====
// Datapath: row of queue slots, insert position mask, occupancy and result register.
module stoq_dpath
  import stoq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int ID_BITS     = DEF_ID_BITS,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int LOG_D      = $clog2(QUEUE_DEPTH),
  localparam int STEP_W     = (LOG_D > 1) ? $clog2(LOG_D) : 1
)
(
  input  logic                clk,
  input  logic                rst,
  input  stoq_cmd_t           cmd,
  output stoq_sts_t           sts,
  input  logic [1:0]          op,
  input  logic [ID_BITS-1:0]  process_id,
  input  logic [KEY_BITS-1:0] start_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic                head_valid,
  output logic [ID_BITS-1:0]  head_id,
  output logic [KEY_BITS-1:0] head_start,
  output logic [CNT_W-1:0]    entry_count
);

  // Captured operation
  logic [1:0]          op_q;
  logic [ID_BITS-1:0]  id_q;
  logic [KEY_BITS-1:0] key_q;

  // Slot row, slot 0 is the head
  logic [ID_BITS-1:0]  cell_id      [QUEUE_DEPTH];
  logic [KEY_BITS-1:0] cell_key     [QUEUE_DEPTH];
  logic [ID_BITS-1:0]  cell_id_next [QUEUE_DEPTH];
  logic [KEY_BITS-1:0] cell_key_next[QUEUE_DEPTH];

  logic [CNT_W-1:0]       occupancy;
  logic [CNT_W-1:0]       occupancy_next;
  logic [CNT_W-1:0]       occ_m1;
  logic [QUEUE_DEPTH-1:0] mask;
  logic [QUEUE_DEPTH-1:0] mask_next;
  logic [QUEUE_DEPTH-1:0] mask_prev;
  logic [STEP_W-1:0]      step;
  logic [1:0]             status_next;
  logic                   is_full;
  logic                   is_empty;

  assign is_full   = (occupancy == CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (occupancy == '0);
  assign occ_m1    = occupancy - CNT_W'(1);
  assign mask_prev = mask << 1;

  assign sts.do_spread   = (op_q == OP_INSERT) && !is_full;
  assign sts.spread_last = (step == STEP_W'(LOG_D - 1));
  assign sts.out_free    = !out_valid || !out_stall;

  // Hold the input transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      id_q  <= process_id;
      key_q <= start_time;
    end
  end

  // Mark slots past the end or with a later start, then spread the first mark toward the tail
  always_comb begin
    mask_next = mask;
    if (cmd.flags) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        mask_next[i] = (CNT_W'(i) >= occupancy) || (cell_key[i] > key_q);
      end
    end else if (cmd.spread) begin
      mask_next = mask | (mask << (1 << step));
    end
  end

  always_ff @(posedge clk) begin
    mask <= mask_next;
    if (cmd.flags) begin
      step <= '0;
    end else if (cmd.spread) begin
      step <= step + STEP_W'(1);
    end
  end

  // Status of the captured operation against the current occupancy
  always_comb begin
    status_next = STAT_DONE;
    if (op_q == OP_INSERT && is_full) begin
      status_next = STAT_FULL;
    end else if (op_q == OP_POP && is_empty) begin
      status_next = STAT_EMPTY;
    end
  end

  // Slot and occupancy updates
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_id_next[i]  = cell_id[i];
      cell_key_next[i] = cell_key[i];
    end
    occupancy_next = occupancy;
    if (cmd.apply) begin
      unique case (op_q)
        OP_INSERT: begin
          if (!is_full) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (mask[i] && !mask_prev[i]) begin
                cell_id_next[i]  = id_q;
                cell_key_next[i] = key_q;
              end
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
              if (mask_prev[i]) begin
                cell_id_next[i]  = cell_id[i-1];
                cell_key_next[i] = cell_key[i-1];
              end
            end
            occupancy_next = occupancy + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (!is_empty) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              cell_id_next[i]  = cell_id[i+1];
              cell_key_next[i] = cell_key[i+1];
            end
            occupancy_next = occ_m1;
          end
        end
        OP_ROTATE: begin
          if (occupancy > CNT_W'(1)) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              if (CNT_W'(i) < occ_m1) begin
                cell_id_next[i]  = cell_id[i+1];
                cell_key_next[i] = cell_key[i+1];
              end
            end
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (CNT_W'(i) == occ_m1) begin
                cell_id_next[i]  = cell_id[0];
                cell_key_next[i] = cell_key[0];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_id[i]  <= cell_id_next[i];
      cell_key[i] <= cell_key_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy_next;
    end
  end

  // Latch status at apply, present the result at emit
  logic [1:0] status_q;

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status_q <= status_next;
    end
    if (cmd.emit) begin
      status      <= status_q;
      head_valid  <= !is_empty;
      head_id     <= is_empty ? '0 : cell_id[0];
      head_start  <= is_empty ? '0 : cell_key[0];
      entry_count <= occupancy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy exceeds queue depth");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && status_next == STAT_FULL |=> $stable(occupancy))
    else $error("dropped insert changed occupancy");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_EMPTY |-> entry_count == '0 && !head_valid)
    else $error("empty pop reported a nonempty queue");

endmodule

// ===== src/start_time_ordered_ready_queue.sv =====
// Top level of the start-time ordered ready queue.
// Holds up to QUEUE_DEPTH process ids kept in start-time order from the head; an insert goes
// ahead of the first entry whose start time is strictly later, so equal start times keep
// arrival order, pop removes the head and rotate moves the head to the tail. Each input
// transfer yields one result with the status, the head entry and the entry count after the
// operation. One operation is in flight at a time and the input stays stalled until it
// finishes: an insert into a non-full queue runs the compare step, then the doubling passes
// that find the insert position across the slot row, then the apply and emit steps; pop,
// rotate and a dropped insert skip the doubling passes. A finished result waits in the
// output register while the next transfer is taken; the next operation then holds in its
// last step, with the input still stalled, for as long as that earlier result is stalled.
module start_time_ordered_ready_queue
  import stoq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int ID_BITS     = DEF_ID_BITS,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          op,
  input  logic [ID_BITS-1:0]  process_id,
  input  logic [KEY_BITS-1:0] start_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic                head_valid,
  output logic [ID_BITS-1:0]  head_id,
  output logic [KEY_BITS-1:0] head_start,
  output logic [CNT_W-1:0]    entry_count
);

  stoq_cmd_t cmd;
  stoq_sts_t sts;

  // Sequence each operation
  stoq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slots, ordering logic and result register
  stoq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .ID_BITS     (ID_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (op),
    .process_id  (process_id),
    .start_time  (start_time),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .head_valid  (head_valid),
    .head_id     (head_id),
    .head_start  (head_start),
    .entry_count (entry_count)
  );

endmodule
